/* design/multicast_sender_history_assert.svh */
// Assertion macros for the checker of the multicast sender history.
`ifndef MULTICAST_SENDER_HISTORY_ASSERT_SVH
`define MULTICAST_SENDER_HISTORY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/msh_pkg.sv */
package msh_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 64;
  localparam int MAX_RUN_DEFAULT       = 64;

  // Request types
  localparam logic [1:0] REQ_DATA      = 2'd0;
  localparam logic [1:0] REQ_NACK      = 2'd1;
  localparam logic [1:0] REQ_HEARTBEAT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA_MID   = 2'd0;
  localparam logic [1:0] KIND_DATA_EOM   = 2'd1;
  localparam logic [1:0] KIND_NOT_AVAIL  = 2'd2;
  localparam logic [1:0] KIND_HEARTBEAT  = 2'd3;

  // Configuration registers
  localparam logic       REG_HISTORY_SIZE   = 1'b0;
  localparam logic [6:0] HISTORY_SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        end_of_message;
    logic [31:0] payload_in;
    logic [31:0] nack_first;
    logic [31:0] nack_stop;
  } req_t;

  typedef struct packed {
    logic [1:0]  packet_kind;
    logic [31:0] packet_id;
    logic [31:0] payload_out;
    logic        last;
  } res_t;

endpackage

/* design/multicast_sender_history.sv */
// Multicast sender history. A request is taken when start is high and busy is low.
// A data request is stored and echoed with its new sequence id, and a heartbeat
// reports the newest sent id; each gives one result in the cycle after it is taken,
// and the block takes the next request in that same cycle, so these run at one
// request per cycle. A NACK for n ids (n cut at MAX_RUN) holds busy while it issues
// its n ids, reading the history memory only for ids still held; its results follow
// one per cycle once busy is set, each registered from its busy step; the single read
// port of the history memory sets that pace. Every result is on res_o for exactly one
// cycle with res_valid_o high: the receiver must take it then, there is no back-pressure.
// The history memory needs no clearing pass after reset: entries outside the stored
// window are never read.
module multicast_sender_history #(
  parameter int HISTORY_DEPTH = msh_pkg::HISTORY_DEPTH_DEFAULT,
  parameter int MAX_RUN       = msh_pkg::MAX_RUN_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          start,
  output logic          busy,
  input  msh_pkg::req_t req_i,
  // result channel
  output logic          res_valid_o,
  output msh_pkg::res_t res_o,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SlotW = $clog2(HISTORY_DEPTH);
  localparam int CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int DiffW = CntW + 1;
  localparam int RunW  = $clog2(MAX_RUN + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Clamp the history size register to 1 .. HISTORY_DEPTH.
  function automatic logic [CntW-1:0] eff_size(input logic [6:0] hs);
    logic [31:0] v;
    v = 32'(hs);
    if (v == 32'd0) begin
      v = 32'd1;
    end else if (v > 32'(HISTORY_DEPTH)) begin
      v = 32'(HISTORY_DEPTH);
    end
    return v[CntW-1:0];
  endfunction

  // Control state
  logic             state_q, state_d;
  logic [6:0]       hist_size_q;
  logic [31:0]      next_id_q, next_id_d;
  logic [CntW-1:0]  stored_q, stored_d;
  logic [SlotW-1:0] wr_slot_q, wr_slot_d;
  logic [31:0]      run_id_q, run_id_d;
  logic [RunW-1:0]  run_left_q, run_left_d;
  logic             res_valid_q, res_valid_d;

  // Result payload registers
  logic [1:0]       out_kind_q, out_kind_d;
  logic [31:0]      out_id_q, out_id_d;
  logic [31:0]      out_pay_q, out_pay_d;
  logic             out_last_q, out_last_d;
  logic             out_mem_q, out_mem_d;   // payload and kind come from the memory

  // History memory: end-of-message bit over payload
  logic [32:0]      hist_mem [HISTORY_DEPTH];
  logic [32:0]      rd_data_q;
  logic             mem_we, mem_re;
  logic [SlotW-1:0] rd_addr;

  logic             accept, cfg_wr;
  logic [CntW-1:0]  size_eff;
  logic [31:0]      span, age;
  logic [RunW-1:0]  run_len;
  logic             hit;
  logic [DiffW-1:0] ws_ext, age_ext, slot_full;

  assign busy   = (state_q == ST_RUN);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == msh_pkg::REG_HISTORY_SIZE);
  assign prdata = (paddr[2] == msh_pkg::REG_HISTORY_SIZE) ? {25'd0, hist_size_q} : 32'd0;

  assign size_eff = eff_size(hist_size_q);

  // NACK run length, cut at MAX_RUN
  assign span    = req_i.nack_stop - req_i.nack_first;
  assign run_len = (span > 32'(MAX_RUN)) ? RunW'(MAX_RUN) : span[RunW-1:0];

  // A requested id is held when its age lies in 1 .. stored count.
  assign age     = next_id_q - run_id_q;
  assign hit     = (age != 32'd0) && (age <= 32'(stored_q));
  assign ws_ext  = DiffW'(wr_slot_q);
  assign age_ext = DiffW'(age[CntW-1:0]);
  assign slot_full = (ws_ext >= age_ext) ? (ws_ext - age_ext)
                                         : (ws_ext + DiffW'(HISTORY_DEPTH) - age_ext);
  assign rd_addr = slot_full[SlotW-1:0];

  // Writes happen only on an accepted data request and reads only while busy,
  // so a write and a read of the same entry never land in the same cycle.
  assign mem_we = accept && (req_i.req_type == msh_pkg::REQ_DATA);
  assign mem_re = busy && hit;

  always_comb begin
    state_d     = state_q;
    next_id_d   = next_id_q;
    stored_d    = stored_q;
    wr_slot_d   = wr_slot_q;
    run_id_d    = run_id_q;
    run_left_d  = run_left_q;
    res_valid_d = 1'b0;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_pay_d   = out_pay_q;
    out_last_d  = out_last_q;
    out_mem_d   = out_mem_q;

    if (busy) begin
      // Issue one id of the run: read the memory if the id is held, register the result fields.
      res_valid_d = 1'b1;
      out_kind_d  = msh_pkg::KIND_NOT_AVAIL;
      out_id_d    = run_id_q;
      out_pay_d   = 32'd0;
      out_last_d  = (run_left_q == RunW'(1));
      out_mem_d   = hit;
      run_id_d    = run_id_q + 32'd1;
      run_left_d  = run_left_q - RunW'(1);
      if (run_left_q == RunW'(1)) begin
        state_d = ST_IDLE;
      end
    end else if (accept) begin
      case (req_i.req_type)
        msh_pkg::REQ_DATA: begin
          res_valid_d = 1'b1;
          out_kind_d  = req_i.end_of_message ? msh_pkg::KIND_DATA_EOM
                                             : msh_pkg::KIND_DATA_MID;
          out_id_d    = next_id_q;
          out_pay_d   = req_i.payload_in;
          out_last_d  = 1'b1;
          out_mem_d   = 1'b0;
          next_id_d   = next_id_q + 32'd1;
          wr_slot_d   = (wr_slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0
                                                                  : wr_slot_q + SlotW'(1);
          stored_d    = (stored_q < size_eff) ? stored_q + CntW'(1) : size_eff;
        end
        msh_pkg::REQ_NACK: begin
          if (run_len != '0) begin
            state_d    = ST_RUN;
            run_id_d   = req_i.nack_first;
            run_left_d = run_len;
          end
        end
        msh_pkg::REQ_HEARTBEAT: begin
          res_valid_d = 1'b1;
          out_kind_d  = msh_pkg::KIND_HEARTBEAT;
          out_id_d    = next_id_q - 32'd1;
          out_pay_d   = 32'd0;
          out_last_d  = 1'b1;
          out_mem_d   = 1'b0;
        end
        default: begin
          // unused request type: drop it
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist_size_q <= msh_pkg::HISTORY_SIZE_RESET;
      next_id_q   <= 32'd0;
      stored_q    <= '0;
      wr_slot_q   <= '0;
      run_id_q    <= 32'd0;
      run_left_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      wr_slot_q   <= wr_slot_d;
      run_id_q    <= run_id_d;
      run_left_q  <= run_left_d;
      res_valid_q <= res_valid_d;
      if (cfg_wr) begin
        // Cut the stored window at once to the new size.
        hist_size_q <= pwdata[6:0];
        stored_q    <= (stored_q > eff_size(pwdata[6:0])) ? eff_size(pwdata[6:0])
                                                         : stored_q;
      end else begin
        stored_q    <= stored_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_pay_q  <= out_pay_d;
    out_last_q <= out_last_d;
    out_mem_q  <= out_mem_d;
  end

  // History memory with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_slot_q] <= {req_i.end_of_message, req_i.payload_in};
    end
    if (mem_re) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  // A replayed packet takes its kind and payload from the memory read data.
  assign res_valid_o       = res_valid_q;
  assign res_o.packet_kind = out_mem_q ? {1'b0, rd_data_q[32]} : out_kind_q;
  assign res_o.packet_id   = out_id_q;
  assign res_o.payload_out = out_mem_q ? rd_data_q[31:0] : out_pay_q;
  assign res_o.last        = out_last_q;

endmodule

/* design/msh_checker.sv */
`include "multicast_sender_history_assert.svh"

module msh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input msh_pkg::req_t req_i,
  input logic          res_valid_o,
  input msh_pkg::res_t res_o
);

  logic data_acc, hb_acc;

  assign data_acc = start && !busy && (req_i.req_type == msh_pkg::REQ_DATA);
  assign hb_acc   = start && !busy && (req_i.req_type == msh_pkg::REQ_HEARTBEAT);

  `MSH_ASSERT_NEXT(a_data_echo, data_acc, res_valid_o && res_o.last && (res_o.packet_kind == msh_pkg::KIND_DATA_MID || res_o.packet_kind == msh_pkg::KIND_DATA_EOM), "data request not echoed next cycle")
  `MSH_ASSERT_NEXT(a_heartbeat, hb_acc, res_valid_o && res_o.last && (res_o.packet_kind == msh_pkg::KIND_HEARTBEAT) && (res_o.payload_out == 32'd0), "heartbeat result malformed")
  `MSH_ASSERT_NOW(a_na_zero, res_valid_o && (res_o.packet_kind == msh_pkg::KIND_NOT_AVAIL), res_o.payload_out == 32'd0, "not-available marker carries payload")
  `MSH_ASSERT_NEXT(a_busy_emits, busy, res_valid_o, "busy cycle gave no result")
  `MSH_ASSERT_NEXT(a_run_cont, res_valid_o && !res_o.last, res_valid_o, "NACK run broke before last")

endmodule

bind multicast_sender_history msh_checker u_msh_checker (.*);
